[hdl/itst_pkg.sv]
package itst_pkg;

    // Field widths
    localparam int PIX_W     = 64;
    localparam int CELL_W    = 32;
    localparam int ZOOM_W    = 7;
    localparam int LIMIT_W   = 33;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_W     = CELL_W + ZOOM_W;

    // Divider split: quotient bits resolved per pipeline stage
    localparam int DIV_STEPS  = 8;
    localparam int DIV_STAGES = CELL_W / DIV_STEPS;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZOOM      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_X   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_Y   = 3'd5;

    // Operation and view codes
    localparam logic OP_TO_TILE   = 1'b0;
    localparam logic OP_TO_SCREEN = 1'b1;
    localparam logic VIEW_ISO     = 1'b0;
    localparam logic VIEW_TOP     = 1'b1;

    // Reset values and projection constants
    localparam logic [ZOOM_W-1:0]  ZOOM_RESET  = 7'd32;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 33'h1_0000_0000;
    localparam logic [ZOOM_W-1:0]  ISO_DIV     = 7'd40;

    typedef struct packed {
        logic                     view_mode;
        logic [ZOOM_W-1:0]        zoom;
        logic signed [PIX_W-1:0]  origin_x;
        logic signed [PIX_W-1:0]  origin_y;
        logic [LIMIT_W-1:0]       limit_x;
        logic [LIMIT_W-1:0]       limit_y;
    } t_cfg;

    // First front stage: raw differences and tile-to-screen offsets
    typedef struct packed {
        logic                     op;
        logic signed [PIX_W-1:0]  ax;
        logic signed [PIX_W-1:0]  ay;
        logic signed [PIX_W-1:0]  tx;
        logic signed [PIX_W-1:0]  mx;
        logic signed [PIX_W-1:0]  my;
    } t_diff;

    // Second front stage: signed numerators and finished screen point
    typedef struct packed {
        logic                     op;
        logic signed [PIX_W-1:0]  nx;
        logic signed [PIX_W-1:0]  ny;
        logic signed [PIX_W-1:0]  pix_x;
        logic signed [PIX_W-1:0]  pix_y;
    } t_num;

    // Divider pipeline word: partial remainder plus numerator/quotient shifter
    typedef struct packed {
        logic                     op;
        logic                     miss;
        logic [ZOOM_W-1:0]        div;
        logic [ZOOM_W-1:0]        rem_x;
        logic [ZOOM_W-1:0]        rem_y;
        logic [CELL_W-1:0]        acc_x;
        logic [CELL_W-1:0]        acc_y;
        logic signed [PIX_W-1:0]  pix_x;
        logic signed [PIX_W-1:0]  pix_y;
    } t_div;

endpackage

[hdl/itst_if.sv]
interface itst_in_if;
    logic                               valid;
    logic                               ready;
    logic                               operation;
    logic signed [itst_pkg::PIX_W-1:0]  pixel_x;
    logic signed [itst_pkg::PIX_W-1:0]  pixel_y;
    logic [itst_pkg::CELL_W-1:0]        cell_x;
    logic [itst_pkg::CELL_W-1:0]        cell_y;

    modport source (output valid, operation, pixel_x, pixel_y, cell_x, cell_y,
                    input ready);
    modport sink (input valid, operation, pixel_x, pixel_y, cell_x, cell_y,
                  output ready);
endinterface

interface itst_out_if;
    logic                               valid;
    logic                               ready;
    logic                               found;
    logic [itst_pkg::CELL_W-1:0]        out_cell_x;
    logic [itst_pkg::CELL_W-1:0]        out_cell_y;
    logic signed [itst_pkg::PIX_W-1:0]  out_pixel_x;
    logic signed [itst_pkg::PIX_W-1:0]  out_pixel_y;

    modport source (output valid, found, out_cell_x, out_cell_y, out_pixel_x,
                    out_pixel_y, input ready);
    modport sink (input valid, found, out_cell_x, out_cell_y, out_pixel_x,
                  out_pixel_y, output ready);
endinterface

interface itst_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [itst_pkg::CFG_IDX_W-1:0]     index;
    logic [itst_pkg::PIX_W-1:0]         data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[hdl/itst_cfg.sv]
module itst_cfg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    itst_cfg_if.sink         i_cfg,
    output itst_pkg::t_cfg   o_cfg
);

    itst_pkg::t_cfg r_cfg;

    // Writes are always taken
    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Load the addressed register, drop writes beyond the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.view_mode <= itst_pkg::VIEW_ISO;
            r_cfg.zoom      <= itst_pkg::ZOOM_RESET;
            r_cfg.origin_x  <= '0;
            r_cfg.origin_y  <= '0;
            r_cfg.limit_x   <= itst_pkg::LIMIT_RESET;
            r_cfg.limit_y   <= itst_pkg::LIMIT_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                itst_pkg::REG_VIEW_MODE: r_cfg.view_mode <= i_cfg.data[0];
                itst_pkg::REG_ZOOM:      r_cfg.zoom <= i_cfg.data[itst_pkg::ZOOM_W-1:0];
                itst_pkg::REG_ORIGIN_X:  r_cfg.origin_x <= i_cfg.data;
                itst_pkg::REG_ORIGIN_Y:  r_cfg.origin_y <= i_cfg.data;
                itst_pkg::REG_LIMIT_X:   r_cfg.limit_x <= i_cfg.data[itst_pkg::LIMIT_W-1:0];
                itst_pkg::REG_LIMIT_Y:   r_cfg.limit_y <= i_cfg.data[itst_pkg::LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

[hdl/itst_front.sv]
module itst_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  itst_pkg::t_cfg   i_cfg,
    itst_in_if.sink          i_in,
    output logic             o_valid,
    input  logic             i_ready,
    output itst_pkg::t_num   o_data
);

    logic            r_a_valid;
    logic            r_b_valid;
    itst_pkg::t_diff r_a;
    itst_pkg::t_num  r_b;
    itst_pkg::t_diff n_a;
    itst_pkg::t_num  n_b;
    logic            a_free;
    logic            b_free;

    logic [itst_pkg::PIX_W-1:0]  k_iso;
    logic [itst_pkg::PIX_W-1:0]  j_iso;
    logic [itst_pkg::NUM_W-1:0]  prod_x;
    logic [itst_pkg::NUM_W-1:0]  prod_y;
    logic signed [itst_pkg::PIX_W-1:0] hx;

    // Stage slots open when empty or draining downstream
    assign b_free     = !r_b_valid || i_ready;
    assign a_free     = !r_a_valid || b_free;
    assign i_in.ready = a_free;
    assign o_valid    = r_b_valid;
    assign o_data     = r_b;

    // Stage A: pixel differences and tile-to-screen offsets
    always_comb begin
        k_iso  = {32'b0, i_in.cell_y} - {32'b0, i_in.cell_x} - 64'd1;
        j_iso  = {31'b0, {1'b0, i_in.cell_y} + {1'b0, i_in.cell_x}};
        prod_x = {32'b0, i_cfg.zoom} * {7'b0, i_in.cell_x};
        prod_y = {32'b0, i_cfg.zoom} * {7'b0, i_in.cell_y};

        n_a.op = i_in.operation;
        n_a.ax = i_in.pixel_x - i_cfg.origin_x;
        n_a.ay = i_in.pixel_y - i_cfg.origin_y;
        n_a.tx = i_cfg.origin_x + {57'b0, i_cfg.zoom} - i_in.pixel_x - 64'd1;
        if (i_cfg.view_mode == itst_pkg::VIEW_ISO) begin
            n_a.mx = (k_iso << 5) + (k_iso << 3);
            n_a.my = (j_iso << 4) + (j_iso << 2);
        end else begin
            n_a.mx = 64'd0 - {25'b0, prod_x};
            n_a.my = {25'b0, prod_y};
        end
    end

    // Stage B: diamond sums or grid numerators, screen point
    always_comb begin
        hx       = $signed(r_a.ax) >>> 1;
        n_b.op    = r_a.op;
        n_b.pix_x = i_cfg.origin_x + r_a.mx;
        n_b.pix_y = i_cfg.origin_y + r_a.my;
        if (i_cfg.view_mode == itst_pkg::VIEW_ISO) begin
            n_b.nx = r_a.ay - hx;
            n_b.ny = r_a.ay + hx;
        end else begin
            n_b.nx = r_a.tx;
            n_b.ny = r_a.ay;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (a_free) begin
                r_a_valid <= i_in.valid;
            end
            if (b_free) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_free) begin
            r_a <= n_a;
        end
        if (b_free) begin
            r_b <= n_b;
        end
    end

endmodule

[hdl/itst_range.sv]
module itst_range (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  itst_pkg::t_cfg   i_cfg,
    input  logic             i_valid,
    output logic             o_ready,
    input  itst_pkg::t_num   i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output itst_pkg::t_div   o_data
);

    logic                               r_valid;
    itst_pkg::t_div                     r_data;
    itst_pkg::t_div                     n_data;
    logic                               is_iso;
    logic [itst_pkg::ZOOM_W-1:0]        dv;
    logic [itst_pkg::NUM_W:0]           lane_x;
    logic [itst_pkg::NUM_W:0]           lane_y;
    logic                               iso_wide_y;

    // Classify one numerator: miss flag and the non-negative dividend
    function automatic logic [itst_pkg::NUM_W:0] prep_lane(
        input logic signed [itst_pkg::PIX_W-1:0] n,
        input logic [itst_pkg::ZOOM_W-1:0]       d,
        input logic                              iso
    );
        logic       big;
        logic       near;
        logic [8:0] t;
        logic       miss;
        logic [itst_pkg::NUM_W-1:0] num;
        begin
            // Quotient would reach 2^32 or more
            big  = (n[62:39] != '0) || (n[38:32] >= d);
            // Small negative value that truncates to quotient zero
            t    = {n[7], n[7:0]} + {2'b00, d};
            near = (&n[62:7]) && !t[8] && (t != '0);
            if (!n[63]) begin
                miss = big;
                num  = n[itst_pkg::NUM_W-1:0];
            end else if (!iso && near) begin
                miss = 1'b0;
                num  = '0;
            end else begin
                miss = 1'b1;
                num  = '0;
            end
            prep_lane = {miss, num};
        end
    endfunction

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Pick divisor, check ranges, seed the divider
    always_comb begin
        is_iso     = (i_cfg.view_mode == itst_pkg::VIEW_ISO);
        dv         = is_iso ? itst_pkg::ISO_DIV : i_cfg.zoom;
        lane_x     = prep_lane(i_data.nx, dv, is_iso);
        lane_y     = prep_lane(i_data.ny, dv, is_iso);
        iso_wide_y = is_iso && (i_data.ny[62:31] != '0);

        n_data.op    = i_data.op;
        n_data.miss  = lane_x[itst_pkg::NUM_W] || lane_y[itst_pkg::NUM_W] || iso_wide_y;
        n_data.div   = dv;
        n_data.rem_x = lane_x[itst_pkg::NUM_W-1:itst_pkg::CELL_W];
        n_data.rem_y = lane_y[itst_pkg::NUM_W-1:itst_pkg::CELL_W];
        n_data.acc_x = lane_x[itst_pkg::CELL_W-1:0];
        n_data.acc_y = lane_y[itst_pkg::CELL_W-1:0];
        n_data.pix_x = i_data.pix_x;
        n_data.pix_y = i_data.pix_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_data <= n_data;
        end
    end

endmodule

[hdl/itst_div_stage.sv]
module itst_div_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  itst_pkg::t_div   i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output itst_pkg::t_div   o_data
);

    logic           r_valid;
    itst_pkg::t_div r_data;
    itst_pkg::t_div n_data;
    logic [itst_pkg::NUM_W-1:0] step_x;
    logic [itst_pkg::NUM_W-1:0] step_y;

    // Restoring division: shift in one numerator bit, subtract when it fits
    function automatic logic [itst_pkg::NUM_W-1:0] div_lane(
        input logic [itst_pkg::ZOOM_W-1:0] rem_in,
        input logic [itst_pkg::CELL_W-1:0] acc_in,
        input logic [itst_pkg::ZOOM_W-1:0] d
    );
        logic [itst_pkg::ZOOM_W-1:0] rem;
        logic [itst_pkg::CELL_W-1:0] acc;
        logic [itst_pkg::ZOOM_W:0]   trial;
        begin
            rem = rem_in;
            acc = acc_in;
            for (int k = 0; k < itst_pkg::DIV_STEPS; k++) begin
                trial = {rem, acc[itst_pkg::CELL_W-1]};
                acc   = {acc[itst_pkg::CELL_W-2:0], 1'b0};
                if (trial >= {1'b0, d}) begin
                    trial  = trial - {1'b0, d};
                    acc[0] = 1'b1;
                end
                rem = trial[itst_pkg::ZOOM_W-1:0];
            end
            div_lane = {rem, acc};
        end
    endfunction

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Resolve the next quotient bits of both lanes
    always_comb begin
        step_x       = div_lane(i_data.rem_x, i_data.acc_x, i_data.div);
        step_y       = div_lane(i_data.rem_y, i_data.acc_y, i_data.div);
        n_data       = i_data;
        n_data.rem_x = step_x[itst_pkg::NUM_W-1:itst_pkg::CELL_W];
        n_data.acc_x = step_x[itst_pkg::CELL_W-1:0];
        n_data.rem_y = step_y[itst_pkg::NUM_W-1:itst_pkg::CELL_W];
        n_data.acc_y = step_y[itst_pkg::CELL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_data <= n_data;
        end
    end

endmodule

[hdl/isometric_tile_screen_transform.sv]
// Channel  Port   Direction  Transaction
// -------  -----  ---------  -------------------------------------------------
// input    i_in   sink       operation, pixel_x/y, cell_x/y
// result   o_out  source     found, out_cell_x/y, out_pixel_x/y
// config   i_cfg  sink       register index and 64-bit write data, always ready
//
// Takes one transaction per cycle while no full stage is held by a stalled result side.
// Eight register stages: three for differences, sums and range checks, four divider
// stages resolving the 32-bit quotient 8 bits each, and the output register.
// Reset clears every stage valid bit and loads the register defaults.
// Each stage holds while the next is full and stalled; empty stages still fill.
module isometric_tile_screen_transform (
    input  logic      i_clk,
    input  logic      i_rst_n,
    itst_in_if.sink   i_in,
    itst_out_if.source o_out,
    itst_cfg_if.sink  i_cfg
);

    itst_pkg::t_cfg cfg;
    logic           front_valid;
    logic           front_ready;
    itst_pkg::t_num front_data;

    logic           div_valid [itst_pkg::DIV_STAGES+1];
    logic           div_ready [itst_pkg::DIV_STAGES+1];
    itst_pkg::t_div div_data  [itst_pkg::DIV_STAGES+1];

    logic           r_out_valid;
    logic           r_found;
    logic [itst_pkg::CELL_W-1:0] r_cell_x;
    logic [itst_pkg::CELL_W-1:0] r_cell_y;
    logic signed [itst_pkg::PIX_W-1:0] r_pix_x;
    logic signed [itst_pkg::PIX_W-1:0] r_pix_y;
    logic           n_found;
    logic [itst_pkg::CELL_W-1:0] n_cell_x;
    logic [itst_pkg::CELL_W-1:0] n_cell_y;
    logic signed [itst_pkg::PIX_W-1:0] n_pix_x;
    logic signed [itst_pkg::PIX_W-1:0] n_pix_y;
    logic           out_free;
    logic           in_x;
    logic           in_y;
    itst_pkg::t_div last;

    itst_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    itst_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .o_valid (front_valid),
        .i_ready (front_ready),
        .o_data  (front_data)
    );

    itst_range u_range (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_data  (front_data),
        .o_valid (div_valid[0]),
        .i_ready (div_ready[0]),
        .o_data  (div_data[0])
    );

    for (genvar g = 0; g < itst_pkg::DIV_STAGES; g++) begin : g_div
        itst_div_stage u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (div_valid[g]),
            .o_ready (div_ready[g]),
            .i_data  (div_data[g]),
            .o_valid (div_valid[g+1]),
            .i_ready (div_ready[g+1]),
            .o_data  (div_data[g+1])
        );
    end

    // Output register drains on ready or fills when empty
    assign out_free                            = !r_out_valid || o_out.ready;
    assign div_ready[itst_pkg::DIV_STAGES]     = out_free;
    assign last                                = div_data[itst_pkg::DIV_STAGES];

    // Limit check and result formatting
    always_comb begin
        in_x = cfg.limit_x[itst_pkg::LIMIT_W-1] ||
               (last.acc_x < cfg.limit_x[itst_pkg::CELL_W-1:0]);
        in_y = cfg.limit_y[itst_pkg::LIMIT_W-1] ||
               (last.acc_y < cfg.limit_y[itst_pkg::CELL_W-1:0]);
        if (last.op == itst_pkg::OP_TO_SCREEN) begin
            n_found  = 1'b1;
            n_cell_x = '0;
            n_cell_y = '0;
            n_pix_x  = last.pix_x;
            n_pix_y  = last.pix_y;
        end else begin
            n_found  = !last.miss && in_x && in_y;
            n_cell_x = n_found ? last.acc_x : '0;
            n_cell_y = n_found ? last.acc_y : '0;
            n_pix_x  = '0;
            n_pix_y  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= div_valid[itst_pkg::DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_found  <= n_found;
            r_cell_x <= n_cell_x;
            r_cell_y <= n_cell_y;
            r_pix_x  <= n_pix_x;
            r_pix_y  <= n_pix_y;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.found       = r_found;
    assign o_out.out_cell_x  = r_cell_x;
    assign o_out.out_cell_y  = r_cell_y;
    assign o_out.out_pixel_x = r_pix_x;
    assign o_out.out_pixel_y = r_pix_y;

endmodule

[tb/sv/tb_isometric_tile_screen_transform.sv]
`timescale 1ns / 1ps

module tb_isometric_tile_screen_transform;
    import itst_pkg::*;

    localparam int          CLK_HALF_NS     = 6;
    localparam int          RESET_CYCLES    = 10;
    localparam int          LATENCY         = 8;
    localparam int          DRAIN_CYCLES    = 2 * LATENCY;
    localparam int          NUM_PHASES      = 8;
    localparam int          ITEMS_PER_PHASE = 150;
    localparam int          HOLD_PHASE      = 2;
    localparam int          HOLD_OFF_CYCLES = 300;
    localparam int unsigned CYCLE_LIMIT     = 400000;

    // Diamond half-extents and the signed 32-bit ceiling of the diagonal sum
    localparam longint ISO_HALF_W  = 40;
    localparam longint ISO_HALF_H  = 20;
    localparam longint ISO_SUM_MAX = 64'sd2147483647;

    localparam longint ORIGIN_MAX = 64'sh7fff_ffff_ffff_ffff;
    localparam longint ORIGIN_MIN = 64'sh8000_0000_0000_0000;

    localparam logic [ZOOM_W-1:0]  ZOOM_MIN       = 7'd12;
    localparam logic [ZOOM_W-1:0]  ZOOM_MAX       = 7'd64;
    localparam logic [ZOOM_W-1:0]  ZOOM_TOP       = 7'd127;
    localparam logic [LIMIT_W-1:0] CELL_LIMIT_CAP = 33'h1_0000_0000;
    localparam logic [LIMIT_W-1:0] LIMIT_ALL_ONES = '1;

    // Indexes past the register list; writes to them must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 3'd7;

    typedef enum {RX_FREE, RX_RANDOM, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    typedef struct packed {
        logic                     op;
        logic signed [PIX_W-1:0]  px;
        logic signed [PIX_W-1:0]  py;
        logic [CELL_W-1:0]        cx;
        logic [CELL_W-1:0]        cy;
    } t_point_req;

    typedef struct packed {
        logic                     found;
        logic [CELL_W-1:0]        cell_x;
        logic [CELL_W-1:0]        cell_y;
        logic signed [PIX_W-1:0]  pix_x;
        logic signed [PIX_W-1:0]  pix_y;
    } t_point_res;

    // Projection predictor with its own register copy and pending results
    class tile_xform_model;
        t_cfg        cfg;
        t_point_res  expected_q[$];
        int unsigned errors;

        function new();
            cfg.view_mode = VIEW_ISO;
            cfg.zoom      = ZOOM_RESET;
            cfg.origin_x  = '0;
            cfg.origin_y  = '0;
            cfg.limit_x   = LIMIT_RESET;
            cfg.limit_y   = LIMIT_RESET;
            errors        = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [PIX_W-1:0] value);
            case (idx)
                REG_VIEW_MODE: cfg.view_mode = value[0];
                REG_ZOOM:      cfg.zoom      = value[ZOOM_W-1:0];
                REG_ORIGIN_X:  cfg.origin_x  = value;
                REG_ORIGIN_Y:  cfg.origin_y  = value;
                REG_LIMIT_X:   cfg.limit_x   = value[LIMIT_W-1:0];
                REG_LIMIT_Y:   cfg.limit_y   = value[LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        function t_point_res project(t_point_req r);
            longint           dx;
            longint           dy;
            longint           half_dx;
            longint           diff;
            longint           sum;
            longint           zl;
            longint           num_x;
            longint           num_y;
            longint           qx;
            longint           qy;
            longint           cap_x;
            longint           cap_y;
            logic [PIX_W-1:0] span;
            bit               hit;
            t_point_res       res;
            res = '0;
            if (r.op == OP_TO_TILE) begin
                hit = 1'b0;
                qx  = 0;
                qy  = 0;
                if (cfg.view_mode == VIEW_ISO) begin
                    // Halve x arithmetically, then split into the two diagonals
                    dy      = r.py - cfg.origin_y;
                    dx      = r.px - cfg.origin_x;
                    half_dx = dx >>> 1;
                    diff    = dy - half_dx;
                    sum     = dy + half_dx;
                    hit     = (diff >= 0) && (sum >= 0) && (sum <= ISO_SUM_MAX);
                    qx      = diff / ISO_HALF_W;
                    qy      = sum / ISO_HALF_W;
                end else if (cfg.zoom != '0) begin
                    // Map x runs leftward; both divisions truncate toward zero
                    zl    = longint'({57'd0, cfg.zoom});
                    num_x = cfg.origin_x + zl - r.px - 1;
                    num_y = r.py - cfg.origin_y;
                    qx    = num_x / zl;
                    qy    = num_y / zl;
                    hit   = (qx >= 0) && (qy >= 0);
                end
                cap_x = (cfg.limit_x > CELL_LIMIT_CAP) ? CELL_LIMIT_CAP : cfg.limit_x;
                cap_y = (cfg.limit_y > CELL_LIMIT_CAP) ? CELL_LIMIT_CAP : cfg.limit_y;
                if (hit && (qx < cap_x) && (qy < cap_y)) begin
                    res.found  = 1'b1;
                    res.cell_x = CELL_W'(qx);
                    res.cell_y = CELL_W'(qy);
                end
            end else begin
                res.found = 1'b1;
                if (cfg.view_mode == VIEW_ISO) begin
                    span      = {32'd0, r.cy} - {32'd0, r.cx} - 64'd1;
                    res.pix_x = cfg.origin_x + ISO_HALF_W * span;
                    res.pix_y = cfg.origin_y + ISO_HALF_H * ({32'd0, r.cy} + {32'd0, r.cx});
                end else begin
                    res.pix_x = cfg.origin_x - {57'd0, cfg.zoom} * {32'd0, r.cx};
                    res.pix_y = cfg.origin_y + {57'd0, cfg.zoom} * {32'd0, r.cy};
                end
            end
            return res;
        endfunction

        function void note_request(t_point_req r);
            expected_q.push_back(project(r));
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        function void compare_field(string name, logic [PIX_W-1:0] want,
                                    logic [PIX_W-1:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch: expected %h, actual %h",
                         $time, name, want, got);
            end
        endfunction

        function void check_result(t_point_res got);
            t_point_res want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual %h", $time, got);
                return;
            end
            want = expected_q.pop_front();
            compare_field("found", want.found, got.found);
            compare_field("out_cell_x", want.cell_x, got.cell_x);
            compare_field("out_cell_y", want.cell_y, got.cell_y);
            compare_field("out_pixel_x", want.pix_x, got.pix_x);
            compare_field("out_pixel_y", want.pix_y, got.pix_y);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   hold_off_req;

    tile_xform_model xform;

    itst_in_if  in_if ();
    itst_out_if out_if ();
    itst_cfg_if cfg_if ();

    isometric_tile_screen_transform uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    initial begin
        clk = 1'b0;
        forever #CLK_HALF_NS clk = ~clk;
    end

    // Track register writes, accepted requests and returned results
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_if.valid && cfg_if.ready)
                xform.write_reg(cfg_if.index, cfg_if.data);
            if (in_if.valid && in_if.ready)
                xform.note_request({in_if.operation, in_if.pixel_x, in_if.pixel_y,
                                    in_if.cell_x, in_if.cell_y});
            if (out_if.valid && out_if.ready)
                xform.check_result({out_if.found, out_if.out_cell_x, out_if.out_cell_y,
                                    out_if.out_pixel_x, out_if.out_pixel_y});
        end
    end

    // Stall the result side on its own pattern; hold off on request
    initial begin : result_receiver
        t_rx_mode    rx_mode;
        int unsigned mode_left;
        bit          rdy;
        out_if.ready <= 1'b0;
        rx_mode   = RX_FREE;
        mode_left = 0;
        forever begin
            @(posedge clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                out_if.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(32, 256);
                end
                mode_left--;
                case (rx_mode)
                    RX_FREE:     rdy = 1'b1;
                    RX_RANDOM:   rdy = ($urandom_range(0, 9) < 7);
                    RX_SPARSE:   rdy = ($urandom_range(0, 3) == 0);
                    RX_PERIODIC: rdy = ((mode_left % 8) < 3);
                    default:     rdy = 1'b1;
                endcase
                out_if.ready <= rdy;
            end
        end
    end

    // Give up if the run stalls
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // Offer one request and hold it until accepted
    task automatic drive_item(input t_point_req r);
        in_if.valid     <= 1'b1;
        in_if.operation <= r.op;
        in_if.pixel_x   <= r.px;
        in_if.pixel_y   <= r.py;
        in_if.cell_x    <= r.cx;
        in_if.cell_y    <= r.cy;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
    endtask

    task automatic send_point(input logic op, input longint px, input longint py,
                              input logic [CELL_W-1:0] cx, input logic [CELL_W-1:0] cy);
        t_point_req r;
        r.op = op;
        r.px = px;
        r.py = py;
        r.cx = cx;
        r.cy = cy;
        drive_item(r);
    endtask

    task automatic idle_input(input int unsigned cycles);
        in_if.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Drop valid and wait for every outstanding result, then let the pipe settle
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (xform.outstanding() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PIX_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Load the whole view; unused upper data bits carry junk
    task automatic program_view(input logic view, input logic [ZOOM_W-1:0] zoom_v,
                                input longint ox, input longint oy,
                                input logic [LIMIT_W-1:0] lx, input logic [LIMIT_W-1:0] ly);
        logic [PIX_W-1:0] junk;
        junk = {$urandom, $urandom};
        write_reg(REG_VIEW_MODE, {junk[PIX_W-1:1], view});
        write_reg(REG_ZOOM, {junk[PIX_W-1:ZOOM_W], zoom_v});
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_LIMIT_X, {junk[PIX_W-1:LIMIT_W], lx});
        write_reg(REG_LIMIT_Y, {junk[PIX_W-1:LIMIT_W], ly});
    endtask

    function automatic longint pick_origin();
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return ORIGIN_MAX;
            2:       return ORIGIN_MIN;
            3:       return longint'({$urandom, $urandom});
            default: return longint'($urandom_range(0, 2097152)) - 1048576;
        endcase
    endfunction

    function automatic logic [LIMIT_W-1:0] pick_limit();
        case ($urandom_range(0, 5))
            0:       return CELL_LIMIT_CAP;
            1:       return LIMIT_ALL_ONES;
            2:       return {1'($urandom_range(0, 1)), $urandom};
            3:       return 33'd1;
            default: return LIMIT_W'($urandom_range(1, 3000));
        endcase
    endfunction

    // Mostly points near the origin so tiles land in the map; some full noise
    function automatic t_point_req gen_point();
        int unsigned shifts[4];
        int unsigned shift;
        logic [63:0] raw;
        longint      span;
        t_point_req  r;
        shifts = '{6, 12, 20, 34};
        r.op = ($urandom_range(0, 1) != 0) ? OP_TO_SCREEN : OP_TO_TILE;
        r.cx = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 4095);
        r.cy = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 4095);
        if ($urandom_range(0, 3) == 0) begin
            r.px = {$urandom, $urandom};
            r.py = {$urandom, $urandom};
        end else begin
            shift = shifts[$urandom_range(0, 3)];
            span  = longint'(64'd1 << shift);
            raw   = {$urandom, $urandom};
            r.px  = xform.cfg.origin_x + (longint'(raw % (2 * span + 1)) - span);
            raw   = {$urandom, $urandom};
            r.py  = xform.cfg.origin_y + (longint'(raw % (2 * span)) - span / 4);
        end
        return r;
    endfunction

    initial begin : stimulus
        int               phase;
        int               n;
        int unsigned      burst_left;
        logic [ZOOM_W-1:0] zoom_pick;
        xform = new();
        hold_off_req = 1'b0;
        rst_n           <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.operation <= OP_TO_TILE;
        in_if.pixel_x   <= '0;
        in_if.pixel_y   <= '0;
        in_if.cell_x    <= '0;
        in_if.cell_y    <= '0;
        cfg_if.valid    <= 1'b0;
        cfg_if.index    <= REG_VIEW_MODE;
        cfg_if.data     <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Isometric at reset defaults: diagonal edges, 32-bit sum ceiling, wrap
        send_point(OP_TO_TILE, 0, 0, 0, 0);
        send_point(OP_TO_TILE, -3, 1, 0, 0);
        send_point(OP_TO_TILE, 3, 1, 0, 0);
        send_point(OP_TO_TILE, 0, ISO_SUM_MAX, 0, 0);
        send_point(OP_TO_TILE, 0, ISO_SUM_MAX + 1, 0, 0);
        send_point(OP_TO_TILE, ORIGIN_MIN, ORIGIN_MAX, '1, '1);
        send_point(OP_TO_TILE, ORIGIN_MAX, ORIGIN_MIN, '1, '1);
        send_point(OP_TO_SCREEN, 0, 0, '0, '0);
        send_point(OP_TO_SCREEN, ORIGIN_MIN, ORIGIN_MAX, '1, '1);
        send_point(OP_TO_SCREEN, 0, 0, '1, '0);
        send_point(OP_TO_SCREEN, 0, 0, '0, '1);
        wait_drained();

        // Writes past the register list, then zero zoom with extreme origins
        write_reg(REG_UNUSED_A, {$urandom, $urandom});
        write_reg(REG_UNUSED_B, {$urandom, $urandom});
        program_view(VIEW_TOP, '0, ORIGIN_MAX, ORIGIN_MIN, LIMIT_ALL_ONES, LIMIT_ALL_ONES);
        send_point(OP_TO_TILE, 0, 0, 0, 0);
        send_point(OP_TO_SCREEN, 0, 0, '1, '1);
        wait_drained();

        // Out-of-range zoom, x limit above the cap, tight y limit
        program_view(VIEW_TOP, ZOOM_TOP, 0, 0, LIMIT_ALL_ONES, 33'd3);
        send_point(OP_TO_TILE, 0, 0, 0, 0);
        send_point(OP_TO_TILE, 127 - (64'sd127 <<< 32), 254, 0, 0);
        send_point(OP_TO_TILE, -(64'sd127 <<< 32), 0, 0, 0);
        send_point(OP_TO_TILE, 0, 381, 0, 0);
        send_point(OP_TO_TILE, 0, -126, 0, 0);
        send_point(OP_TO_TILE, 128, 0, 0, 0);
        send_point(OP_TO_TILE, 254, 0, 0, 0);
        wait_drained();

        // Empty map and unit zoom at the origin extremes
        program_view(VIEW_TOP, 7'd1, ORIGIN_MIN, ORIGIN_MAX, '0, '0);
        send_point(OP_TO_TILE, 0, 0, 0, 0);
        send_point(OP_TO_SCREEN, 0, 0, '1, '1);

        // Random phases, each under its own view setting
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            wait_drained();
            case (phase)
                0: program_view(VIEW_ISO, ZOOM_MIN, 0, 0, CELL_LIMIT_CAP, CELL_LIMIT_CAP);
                1: program_view(VIEW_TOP, ZOOM_MIN, pick_origin(), pick_origin(),
                                33'd40, 33'd40);
                2: program_view(VIEW_TOP, ZOOM_MAX, ORIGIN_MAX, ORIGIN_MIN,
                                LIMIT_ALL_ONES, CELL_LIMIT_CAP);
                3: program_view(VIEW_ISO, ZOOM_MAX, ORIGIN_MIN, ORIGIN_MAX,
                                33'd1500, 33'd1);
                default: begin
                    case ($urandom_range(0, 5))
                        0:       zoom_pick = '0;
                        1:       zoom_pick = ZOOM_W'($urandom_range(1, 127));
                        2:       zoom_pick = ZOOM_MIN;
                        3:       zoom_pick = ZOOM_MAX;
                        default: zoom_pick = ZOOM_W'($urandom_range(12, 64));
                    endcase
                    program_view($urandom_range(0, 1) ? VIEW_TOP : VIEW_ISO, zoom_pick,
                                 pick_origin(), pick_origin(), pick_limit(), pick_limit());
                end
            endcase
            // Let the result side back up while requests keep coming
            if (phase == HOLD_PHASE)
                hold_off_req = 1'b1;
            burst_left = 0;
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    if ($urandom_range(0, 3) != 0)
                        idle_input($urandom_range(1, 15));
                end
                burst_left--;
                drive_item(gen_point());
            end
        end
        wait_drained();

        if (xform.errors == 0 && xform.outstanding() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
